### design/prs_pkg.sv
package prs_pkg;

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_CLEAR = 2'd1,
    FN_RUN   = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_SIDE   = 2'd0,
    CFG_METHOD = 2'd1,
    CFG_TOL    = 2'd2,
    CFG_MAXSW  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WS_ZERO  = 2'd0,
    WS_RELAX = 2'd1,
    WS_COPY  = 2'd2
  } wr_sel_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [9:0]         cell_address;
    logic signed [31:0] source_value;
  } prs_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [15:0]        sweeps_done;
    logic               converged;
  } prs_out_t;

  // controller -> datapath
  typedef struct packed {
    logic    sum_clr;
    logic    cap_center;
    logic    cap_nbr;
    logic    calc;
    logic    sq_en;
    logic    sq_diff;
    logic    acc_clr;
    logic    sol_we;
    logic    nxt_we;
    logic    src_we;
    wr_sel_t wr_sel;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic met;
  } dp_stat_t;

endpackage

### design/prs_datapath.sv
module prs_datapath
  import prs_pkg::*;
#(
  parameter int MAX_SIDE    = 32,
  parameter int VALUE_WIDTH = 32,
  localparam int CELLS = MAX_SIDE * MAX_SIDE,
  localparam int IW    = $clog2(CELLS)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dp_cmd_t                       cmd,
  input  logic [IW-1:0]                 rd_addr,
  input  logic [IW-1:0]                 wr_addr,
  input  logic signed [31:0]            src_value,
  input  logic [15:0]                   tol,
  output logic signed [VALUE_WIDTH-1:0] sol_q,
  output dp_stat_t                      stat
);

  localparam int VW = VALUE_WIDTH;
  localparam int SW = VW + 2;
  localparam int TW = VW + 3;
  localparam int DW = VW + 1;
  localparam int EW = ((VW > 32) ? VW : 32) + 1;
  localparam logic signed [TW-1:0] VMAX_T = {{(TW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [TW-1:0] VMIN_T = ~VMAX_T;
  localparam logic signed [EW-1:0] VMAX_E = {{(EW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [EW-1:0] VMIN_E = ~VMAX_E;

  logic signed [VW-1:0] sol_mem [CELLS];
  logic signed [VW-1:0] nxt_mem [CELLS];
  logic signed [VW-1:0] src_mem [CELLS];

  logic signed [VW-1:0] nxt_q, src_q, center, src_c, relax_val, wr_val, src_sat;
  logic signed [SW-1:0] sum, quarter;
  logic signed [TW-1:0] relax_raw;
  logic signed [EW-1:0] src_ext;
  logic signed [DW-1:0] sq_op;
  logic [DW-1:0]        sq_mag;
  logic [63:0]          mag64, sq_val, diff_acc, norm_acc;
  logic [64:0]          acc_sum;
  logic                 op_vld, op_diff, sq_vld, sq_is_diff;
  logic [31:0]          tol_sq;
  logic [63:0]          prod_lo, prod_hi;
  logic [95:0]          rhs;

  always_comb begin
    quarter   = sum >>> 2;
    relax_raw = TW'(quarter) - TW'(src_c);
    src_ext   = EW'(src_value);
    if (src_ext > VMAX_E) begin
      src_sat = VW'(VMAX_E);
    end else if (src_ext < VMIN_E) begin
      src_sat = VW'(VMIN_E);
    end else begin
      src_sat = VW'(src_ext);
    end
    case (cmd.wr_sel)
      WS_RELAX: wr_val = relax_val;
      WS_COPY:  wr_val = nxt_q;
      default:  wr_val = '0;
    endcase
  end

  // grids: one read address shared by all three
  always_ff @(posedge clk) begin
    sol_q <= sol_mem[rd_addr];
    nxt_q <= nxt_mem[rd_addr];
    src_q <= src_mem[rd_addr];
    if (cmd.sol_we) begin
      sol_mem[wr_addr] <= wr_val;
    end
    if (cmd.nxt_we) begin
      nxt_mem[wr_addr] <= relax_val;
    end
    if (cmd.src_we) begin
      src_mem[wr_addr] <= src_sat;
    end
  end

  // stencil sum and relaxed value
  always_ff @(posedge clk) begin
    if (cmd.cap_center) begin
      center <= sol_q;
      src_c  <= src_q;
    end
    if (cmd.sum_clr) begin
      sum <= '0;
    end else if (cmd.cap_nbr) begin
      sum <= sum + SW'(sol_q);
    end
    if (cmd.calc) begin
      if (relax_raw > VMAX_T) begin
        relax_val <= VW'(VMAX_T);
      end else if (relax_raw < VMIN_T) begin
        relax_val <= VW'(VMIN_T);
      end else begin
        relax_val <= VW'(relax_raw);
      end
    end
  end

  // square and accumulate, saturating at all ones
  assign sq_mag  = sq_op[DW-1] ? DW'(-sq_op) : DW'(sq_op);
  assign mag64   = 64'(sq_mag);
  assign acc_sum = {1'b0, (sq_is_diff ? diff_acc : norm_acc)} + {1'b0, sq_val};

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      sq_op   <= cmd.sq_diff ? (DW'(relax_val) - DW'(center)) : DW'(center);
      op_diff <= cmd.sq_diff;
    end
    sq_val     <= (|mag64[63:32]) ? '1 : (mag64[31:0] * mag64[31:0]);
    sq_is_diff <= op_diff;
    if (cmd.acc_clr) begin
      diff_acc <= '0;
      norm_acc <= '0;
    end else if (sq_vld) begin
      if (sq_is_diff) begin
        diff_acc <= acc_sum[64] ? '1 : acc_sum[63:0];
      end else begin
        norm_acc <= acc_sum[64] ? '1 : acc_sum[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_vld <= 1'b0;
      sq_vld <= 1'b0;
    end else begin
      op_vld <= cmd.sq_en;
      sq_vld <= op_vld;
    end
  end

  // diff * 2^32 < tol^2 * norm, split into 32-bit products; zero norm needs zero diff
  always_ff @(posedge clk) begin
    tol_sq  <= tol * tol;
    prod_lo <= norm_acc[31:0] * tol_sq;
    prod_hi <= norm_acc[63:32] * tol_sq;
    rhs     <= {32'd0, prod_lo} + {prod_hi, 32'd0};
    if (norm_acc == '0) begin
      stat.met <= (diff_acc == '0);
    end else begin
      stat.met <= ({diff_acc, 32'd0} < rhs);
    end
  end

endmodule

### design/prs_ctrl.sv
module prs_ctrl
  import prs_pkg::*;
#(
  parameter int MAX_SIDE    = 32,
  parameter int VALUE_WIDTH = 32,
  localparam int CELLS = MAX_SIDE * MAX_SIDE,
  localparam int IW    = $clog2(CELLS),
  localparam int CW    = IW + 1,
  localparam int NW    = $clog2(MAX_SIDE + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  prs_in_t                       in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output prs_out_t                      out_data,
  input  logic [NW-1:0]                 side,
  input  logic                          method,
  input  logic [15:0]                   max_sweeps,
  output dp_cmd_t                       cmd,
  output logic [IW-1:0]                 rd_addr,
  output logic [IW-1:0]                 wr_addr,
  input  logic signed [VALUE_WIDTH-1:0] sol_q,
  input  dp_stat_t                      stat
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_READ, S_READ2, S_SWEEP, S_CELL,
    S_COPY_RD, S_COPY_WR, S_CHECK, S_RESP
  } state_t;

  state_t      state;
  logic [CW-1:0] cnt, ncells;
  logic [NW-1:0] row, col;
  logic [2:0]    step;
  logic [15:0]   sweeps, sweeps_next, cap;
  logic          addr_ok, clr_resp, last_cell, accept;
  logic [IW-1:0] item_addr;
  prs_out_t      res;

  assign ncells      = CW'(side) * CW'(side);
  assign addr_ok     = {{CW{1'b0}}, in_data.cell_address} < {10'd0, ncells};
  assign last_cell   = (cnt + CW'(1)) == ncells;
  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state != S_IDLE);
  assign sweeps_next = sweeps + 16'd1;
  assign cap         = (max_sweeps == 16'd0) ? 16'd1 : max_sweeps;

  always_comb begin
    cmd     = '0;
    rd_addr = IW'(cnt);
    wr_addr = IW'(cnt);
    case (state)
      S_CLR: begin
        cmd.sol_we = 1'b1;
        cmd.wr_sel = WS_ZERO;
      end
      S_IDLE: begin
        wr_addr    = IW'(in_data.cell_address);
        cmd.src_we = accept && (in_data.func == FN_WRITE) && addr_ok;
      end
      S_READ: rd_addr = item_addr;
      S_SWEEP: cmd.acc_clr = 1'b1;
      S_CELL: begin
        case (step)
          3'd0: cmd.sum_clr = 1'b1;
          3'd1: begin
            rd_addr        = IW'(cnt - CW'(1));
            cmd.cap_center = 1'b1;
          end
          3'd2: begin
            rd_addr     = IW'(cnt + CW'(1));
            cmd.cap_nbr = (col != '0);
            cmd.sq_en   = 1'b1;
          end
          3'd3: begin
            rd_addr     = IW'(cnt - CW'(side));
            cmd.cap_nbr = (col != side - NW'(1));
          end
          3'd4: begin
            rd_addr     = IW'(cnt + CW'(side));
            cmd.cap_nbr = (row != '0);
          end
          3'd5: cmd.cap_nbr = (row != side - NW'(1));
          3'd6: cmd.calc = 1'b1;
          default: begin
            cmd.sq_en   = 1'b1;
            cmd.sq_diff = 1'b1;
            cmd.wr_sel  = WS_RELAX;
            cmd.sol_we  = method;
            cmd.nxt_we  = !method;
          end
        endcase
      end
      S_COPY_WR: begin
        cmd.sol_we = 1'b1;
        cmd.wr_sel = WS_COPY;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      clr_resp  <= 1'b0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      // S_RESP reloads the output register itself
      if (out_valid && !out_stall && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(CELLS - 1)) begin
            state <= clr_resp ? S_RESP : S_IDLE;
          end
        end
        S_IDLE: begin
          res <= '0;
          if (accept) begin
            item_addr <= IW'(in_data.cell_address);
            clr_resp  <= 1'b1;
            cnt       <= '0;
            sweeps    <= '0;
            case (in_data.func)
              FN_CLEAR: state <= S_CLR;
              FN_RUN:   state <= S_SWEEP;
              FN_READ: begin
                state <= addr_ok ? S_READ : S_RESP;
              end
              default:  state <= S_RESP;
            endcase
          end
        end
        S_READ:  state <= S_READ2;
        S_READ2: begin
          res.read_value <= 32'(sol_q);
          state          <= S_RESP;
        end
        S_SWEEP: begin
          cnt   <= '0;
          row   <= '0;
          col   <= '0;
          step  <= '0;
          state <= S_CELL;
        end
        S_CELL: begin
          step <= step + 3'd1;
          if (step == 3'd7) begin
            cnt <= cnt + CW'(1);
            if (col == side - NW'(1)) begin
              col <= '0;
              row <= row + NW'(1);
            end else begin
              col <= col + NW'(1);
            end
            if (last_cell) begin
              cnt   <= '0;
              state <= method ? S_CHECK : S_COPY_RD;
            end
          end
        end
        S_COPY_RD: state <= S_COPY_WR;
        S_COPY_WR: begin
          cnt   <= cnt + CW'(1);
          state <= S_COPY_RD;
          if (last_cell) begin
            cnt   <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // wait for the square pipe and the tolerance compare to settle
          cnt <= cnt + CW'(1);
          if (cnt == CW'(7)) begin
            sweeps <= sweeps_next;
            if (stat.met || (sweeps_next >= cap)) begin
              res.sweeps_done <= sweeps_next;
              res.converged   <= stat.met;
              state           <= S_RESP;
            end else begin
              state <= S_SWEEP;
            end
          end
        end
        S_RESP: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cell_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_CELL |-> cnt < ncells)
    else $error("cell index past grid");
  a_rowcol_in_side: assert property (@(posedge clk) disable iff (rst)
    state == S_CELL |-> (row < side) && (col < side))
    else $error("row or column past side");
  a_stall_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("input taken during clearing pass");
`endif

endmodule

### design/poisson_relaxation_solver_core.sv
// Five-point Poisson relaxation solver, Q16.16 values, zero boundary.
// Input channel (in_valid/in_stall/in_data) carries one command per transfer:
//   write source cell, clear solution, run sweeps to convergence, read cell.
// Output channel (out_valid/out_stall/out_data) returns exactly one result
// per command: read_value for reads, sweeps_done/converged for runs, else 0.
// Config port (cfg_we/cfg_index/cfg_data) writes side, method, tolerance or
// sweep cap, one per write; write only while no command is in flight.
// A run does, per sweep and per cell, five reads through the single solution
// read port, a relax step and a write back; the Jacobi method adds a copy
// pass, and the convergence compare ends each sweep. One command is
// processed at a time; in_stall is high until the result is registered.
// Reset: config regs take their defaults and a clearing pass over all
// MAX_SIDE^2 cells zeroes the solution grid with in_stall held high.
// A stalled result holds in the output register; the next command can be
// taken meanwhile, and its result waits until the register frees up.
module poisson_relaxation_solver_core
  import prs_pkg::*;
#(
  parameter int MAX_SIDE    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  prs_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output prs_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int IW    = $clog2(CELLS);
  localparam int NW    = $clog2(MAX_SIDE + 1);

  logic [5:0]    inner_side;
  logic          method_select;
  logic [15:0]   tolerance, max_sweeps;
  logic [NW-1:0] side;

  dp_cmd_t                       cmd;
  dp_stat_t                      stat;
  logic [IW-1:0]                 rd_addr, wr_addr;
  logic signed [VALUE_WIDTH-1:0] sol_q;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inner_side    <= 6'd32;
      method_select <= 1'b0;
      tolerance     <= 16'd66;
      max_sweeps    <= 16'd10000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIDE:   inner_side    <= cfg_data[5:0];
        CFG_METHOD: method_select <= cfg_data[0];
        CFG_TOL:    tolerance     <= cfg_data;
        CFG_MAXSW:  max_sweeps    <= cfg_data;
        default: ;
      endcase
    end
  end

  // side clamped to 2..MAX_SIDE
  always_comb begin
    if (inner_side < 6'd2) begin
      side = NW'(2);
    end else if (32'(inner_side) > MAX_SIDE) begin
      side = NW'(MAX_SIDE);
    end else begin
      side = NW'(inner_side);
    end
  end

  prs_ctrl #(
    .MAX_SIDE    (MAX_SIDE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .side       (side),
    .method     (method_select),
    .max_sweeps (max_sweeps),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .sol_q      (sol_q),
    .stat       (stat)
  );

  prs_datapath #(
    .MAX_SIDE    (MAX_SIDE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .src_value (in_data.source_value),
    .tol       (tolerance),
    .sol_q     (sol_q),
    .stat      (stat)
  );

endmodule
